>>> design/tbsr_pkg.sv
// tbsr_pkg: shared types and constants of the tile background scanline renderer
// no dependencies; imported by every module of the block but tbsr_dual_read_ram
`default_nettype none

package tbsr_pkg;

  localparam int TILES_PER_ROW = 32;
  localparam int SLOT_W        = 6;
  // slot 0 fetches the guard attribute, slots 1 .. TILES_PER_ROW+1 fetch the tiles
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TILES_PER_ROW + 1);
  localparam logic [SLOT_W-1:0] GUARD_SLOT = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] FIRST_OUT_SLOT = SLOT_W'(2);

  localparam int PAT_ADDR_W = 13;
  localparam int NT_ADDR_W  = 12;
  localparam int PAL_ADDR_W = 4;
  localparam int BYTE_W     = 8;
  localparam int CFG_INDEX_W = 1;

  // attribute area starts at 0x3c0 inside each 1 KB table
  localparam logic [3:0] ATTR_AREA_HI = 4'b1111;

  typedef enum logic [1:0] {
    KIND_PATTERN = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_PALETTE = 2'd2,
    KIND_RENDER  = 2'd3
  } kind_t;

  localparam logic [CFG_INDEX_W-1:0] REG_BG_PATTERN_HALF      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_LEFT_BACKGROUND = 1'b1;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] address;
    logic [7:0]  data;
    logic [14:0] scroll_address;
    logic [2:0]  fine_x;
  } req_word_t;

  typedef struct packed {
    logic [7:0] pixel_0;
    logic [7:0] pixel_1;
    logic [7:0] pixel_2;
    logic [7:0] pixel_3;
    logic [7:0] pixel_4;
    logic [7:0] pixel_5;
    logic [7:0] pixel_6;
    logic [7:0] pixel_7;
    logic       last;
  } pix_word_t;

  // tile slot leaving the name table read
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [2:0]        shift;
  } fetch_meta_t;

  // tile slot leaving the pattern and palette read
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } stage_meta_t;

endpackage

`default_nettype wire

>>> design/tbsr_dual_read_ram.sv
// tbsr_dual_read_ram: one write port, two registered read ports sharing an enable
// depends on nothing; sized by its parameters
`default_nettype none

module tbsr_dual_read_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr_a,
  input  wire logic [ADDR_W-1:0] rd_addr_b,
  output logic      [DATA_W-1:0] rd_data_a,
  output logic      [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

>>> design/tbsr_palette_ram.sv
// tbsr_palette_ram: 16-byte palette held as four rows of four bytes
// byte writes, one registered row read; uses tbsr_pkg
`default_nettype none

module tbsr_palette_ram (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [tbsr_pkg::PAL_ADDR_W-1:0] wr_addr,
  input  wire logic [tbsr_pkg::BYTE_W-1:0]     wr_data,
  input  wire logic                            rd_en,
  input  wire logic [1:0]                      rd_row,
  output logic      [3:0][tbsr_pkg::BYTE_W-1:0] rd_data
);
  import tbsr_pkg::*;

  logic [3:0][BYTE_W-1:0] mem [4];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[3:2]][wr_addr[1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

`default_nettype wire

>>> design/tbsr_tile_seq.sv
// tbsr_tile_seq: walks the tile slots of one line and drives the name table reads
// uses tbsr_pkg
`default_nettype none

module tbsr_tile_seq (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [14:0]                    scroll_address,
  input  wire logic [2:0]                     fine_x,
  input  wire logic                           adv,
  output logic      [tbsr_pkg::NT_ADDR_W-1:0] name_addr,
  output logic      [tbsr_pkg::NT_ADDR_W-1:0] attr_addr,
  output tbsr_pkg::fetch_meta_t               meta1,
  output logic                                running,
  output logic      [2:0]                     fine_y_q,
  output logic      [2:0]                     fine_x_q
);
  import tbsr_pkg::*;

  seq_state_t        state, state_next;
  logic [SLOT_W-1:0] slot;
  logic [4:0]        cx;
  logic [4:0]        cy;
  logic [1:0]        nt_sel;
  logic [1:0]        nt_cur;

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (start) state_next = SEQ_RUN;
      end
      SEQ_RUN: begin
        if (adv && slot == LAST_SLOT) state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    running = 1'b0;
    case (state)
      SEQ_IDLE: running = 1'b0;
      SEQ_RUN:  running = 1'b1;
      default:  running = 1'b0;
    endcase
  end

  // the guard slot reads the attribute of the tile one full row ahead
  assign nt_cur    = (slot == GUARD_SLOT) ? {nt_sel[1], ~nt_sel[0]} : nt_sel;
  assign name_addr = {nt_cur, cy, cx};
  assign attr_addr = {nt_cur, ATTR_AREA_HI, cy[4:2], cx[4:2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == SEQ_IDLE) begin
      slot     <= GUARD_SLOT;
      cx       <= scroll_address[4:0];
      cy       <= scroll_address[9:5];
      nt_sel   <= scroll_address[11:10];
      fine_y_q <= scroll_address[14:12];
      fine_x_q <= fine_x;
    end else if (running && adv) begin
      slot <= slot + SLOT_W'(1);
      if (slot != GUARD_SLOT) begin
        cx <= cx + 5'd1;
        if (cx == 5'd31) nt_sel[0] <= ~nt_sel[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta1.valid <= 1'b0;
    end else if (adv) begin
      meta1.valid <= running;
      meta1.slot  <= slot;
      meta1.shift <= {cy[1], cx[1], 1'b0};
    end
  end

endmodule

`default_nettype wire

>>> design/tbsr_pixel_out.sv
// tbsr_pixel_out: turns pattern planes into palette bytes, aligns by fine x, clips
// holds the output word register; uses tbsr_pkg
`default_nettype none

module tbsr_pixel_out (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            adv,
  input  wire tbsr_pkg::fetch_meta_t           meta1,
  input  wire logic [7:0]                      plane_lo,
  input  wire logic [7:0]                      plane_hi,
  input  wire logic [3:0][tbsr_pkg::BYTE_W-1:0] pal_row,
  input  wire logic [2:0]                      fine_x,
  input  wire logic                            show_left_background,
  output tbsr_pkg::stage_meta_t                meta2,
  output logic                                 pix_valid,
  output tbsr_pkg::pix_word_t                  pix_word
);
  import tbsr_pkg::*;

  logic [7:0]         cur_pix [8];
  logic [7:0]         prev_pix [8];
  logic [15:0][7:0]   window;
  logic [7:0]         sel_pix [8];
  logic [7:0]         clip_value;
  logic               emit;
  logic               clip;
  pix_word_t          pix_word_next;

  always_comb begin
    for (int p = 0; p < 8; p++) begin
      cur_pix[p] = pal_row[{plane_hi[7-p], plane_lo[7-p]}];
    end
  end

  // left tile then right tile, pick eight starting at fine x
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      window[i]     = prev_pix[i];
      window[i + 8] = cur_pix[i];
    end
    for (int j = 0; j < 8; j++) begin
      sel_pix[j] = window[4'(j) + {1'b0, fine_x}];
    end
  end

  assign emit = meta2.valid && (meta2.slot >= FIRST_OUT_SLOT);
  assign clip = !show_left_background && (meta2.slot == FIRST_OUT_SLOT);

  always_comb begin
    pix_word_next.pixel_0 = clip ? clip_value : sel_pix[0];
    pix_word_next.pixel_1 = clip ? clip_value : sel_pix[1];
    pix_word_next.pixel_2 = clip ? clip_value : sel_pix[2];
    pix_word_next.pixel_3 = clip ? clip_value : sel_pix[3];
    pix_word_next.pixel_4 = clip ? clip_value : sel_pix[4];
    pix_word_next.pixel_5 = clip ? clip_value : sel_pix[5];
    pix_word_next.pixel_6 = clip ? clip_value : sel_pix[6];
    pix_word_next.pixel_7 = clip ? clip_value : sel_pix[7];
    pix_word_next.last    = (meta2.slot == LAST_SLOT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta2.valid <= 1'b0;
      pix_valid   <= 1'b0;
    end else if (adv) begin
      meta2.valid <= meta1.valid;
      meta2.slot  <= meta1.slot;
      pix_valid   <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (meta2.valid && meta2.slot == GUARD_SLOT) begin
        clip_value <= pal_row[0];
      end
      if (meta2.valid && meta2.slot != GUARD_SLOT) begin
        for (int p = 0; p < 8; p++) prev_pix[p] <= cur_pix[p];
      end
      if (emit) begin
        pix_word <= pix_word_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/tile_background_scanline_render.sv
// tile_background_scanline_render: top level of the tile background line renderer
// uses tbsr_pkg, tbsr_dual_read_ram, tbsr_palette_ram, tbsr_tile_seq, tbsr_pixel_out
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+---------------------------------------
//  req     | in        | req_valid/req_stall | kind, address, data, scroll, fine x
//  pix     | out       | pix_valid/pix_stall | eight palette bytes and last
//  cfg     | in        | cfg_valid/cfg_ready | register index and one data bit
//
// a render word runs 34 fetch slots (one guard attribute fetch, then 33 tiles)
// through a three-deep read pipeline and yields 32 pix words
// req_stall stays high until the sequencer and both read stages are empty; the last pix word may still wait
// pix_stall, while a pix word is held, freezes the whole fetch pipeline, memory read registers included
// reset clears the config registers and control state, not the stores
`default_nettype none

module tile_background_scanline_render (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire tbsr_pkg::req_word_t               req_word,
  output logic                                   pix_valid,
  input  wire logic                              pix_stall,
  output tbsr_pkg::pix_word_t                    pix_word,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tbsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic                              cfg_data
);
  import tbsr_pkg::*;

  logic bg_pattern_half;
  logic show_left_background;

  logic req_accept;
  logic start;
  logic adv;
  logic running;

  logic [NT_ADDR_W-1:0]  name_addr;
  logic [NT_ADDR_W-1:0]  attr_addr;
  logic [BYTE_W-1:0]     name_q;
  logic [BYTE_W-1:0]     attr_q;
  logic [PAT_ADDR_W-1:0] pat_lo_addr;
  logic [PAT_ADDR_W-1:0] pat_hi_addr;
  logic [BYTE_W-1:0]     plane_lo;
  logic [BYTE_W-1:0]     plane_hi;
  logic [1:0]            group;
  logic [3:0][BYTE_W-1:0] pal_row;
  logic [2:0]            fine_y_q;
  logic [2:0]            fine_x_q;

  fetch_meta_t meta1;
  stage_meta_t meta2;

  // config port is always open; the user must write only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_pattern_half      <= 1'b0;
      show_left_background <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BG_PATTERN_HALF:      bg_pattern_half      <= cfg_data;
        REG_SHOW_LEFT_BACKGROUND: show_left_background <= cfg_data;
        default: ;
      endcase
    end
  end

  // one word at a time: hold off while any tile slot is still in flight
  assign req_stall  = running || meta1.valid || meta2.valid;
  assign req_accept = req_valid && !req_stall;
  assign start      = req_accept && (req_word.kind == KIND_RENDER);

  // pipeline moves whenever the output register is free or being drained
  assign adv = !pix_valid || !pix_stall;

  tbsr_tile_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .scroll_address (req_word.scroll_address),
    .fine_x         (req_word.fine_x),
    .adv            (adv),
    .name_addr      (name_addr),
    .attr_addr      (attr_addr),
    .meta1          (meta1),
    .running        (running),
    .fine_y_q       (fine_y_q),
    .fine_x_q       (fine_x_q)
  );

  // four 1 KB name tables; port a reads the name, port b the attribute
  tbsr_dual_read_ram #(
    .ADDR_W (NT_ADDR_W),
    .DATA_W (BYTE_W)
  ) u_name_ram (
    .clk       (clk),
    .wr_en     (req_accept && req_word.kind == KIND_NAME),
    .wr_addr   (req_word.address[NT_ADDR_W-1:0]),
    .wr_data   (req_word.data),
    .rd_en     (adv),
    .rd_addr_a (name_addr),
    .rd_addr_b (attr_addr),
    .rd_data_a (name_q),
    .rd_data_b (attr_q)
  );

  // palette group from the attribute quadrant, pattern rows from the name byte
  assign group       = 2'(attr_q >> meta1.shift);
  assign pat_lo_addr = {bg_pattern_half, name_q, 1'b0, fine_y_q};
  assign pat_hi_addr = {bg_pattern_half, name_q, 1'b1, fine_y_q};

  tbsr_dual_read_ram #(
    .ADDR_W (PAT_ADDR_W),
    .DATA_W (BYTE_W)
  ) u_pattern_ram (
    .clk       (clk),
    .wr_en     (req_accept && req_word.kind == KIND_PATTERN),
    .wr_addr   (req_word.address),
    .wr_data   (req_word.data),
    .rd_en     (adv),
    .rd_addr_a (pat_lo_addr),
    .rd_addr_b (pat_hi_addr),
    .rd_data_a (plane_lo),
    .rd_data_b (plane_hi)
  );

  tbsr_palette_ram u_palette_ram (
    .clk     (clk),
    .wr_en   (req_accept && req_word.kind == KIND_PALETTE),
    .wr_addr (req_word.address[PAL_ADDR_W-1:0]),
    .wr_data (req_word.data),
    .rd_en   (adv),
    .rd_row  (group),
    .rd_data (pal_row)
  );

  // guard slot latches the clip color, tile slots build the aligned words
  tbsr_pixel_out u_pixel_out (
    .clk                  (clk),
    .rst                  (rst),
    .adv                  (adv),
    .meta1                (meta1),
    .plane_lo             (plane_lo),
    .plane_hi             (plane_hi),
    .pal_row              (pal_row),
    .fine_x               (fine_x_q),
    .show_left_background (show_left_background),
    .meta2                (meta2),
    .pix_valid            (pix_valid),
    .pix_word             (pix_word)
  );

`ifndef SYNTH
  // a render word keeps the request side closed on the next cycle
  a_render_blocks: assert property (@(posedge clk) disable iff (rst)
    start |=> req_stall)
    else $error("render word accepted but request side not stalled");

  // slot numbers in flight never pass the last tile
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    meta1.valid |-> (meta1.slot <= LAST_SLOT))
    else $error("tile slot beyond end of line");

  // last tile through the pixel stage yields the word marked last
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (adv && meta2.valid && meta2.slot == LAST_SLOT) |=> (pix_valid && pix_word.last))
    else $error("last tile did not produce the last word");

  // nothing of a new line reaches the pixel stage before the last word leaves
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_word.last) |-> !meta2.valid)
    else $error("pixel stage busy while last word pending");
`endif

endmodule

`default_nettype wire

>>> verif/tb_tile_background_scanline_render.sv
`timescale 1ns / 1ps
// tb_tile_background_scanline_render: self-checking bench for the tile background line renderer
// depends on tbsr_pkg and tile_background_scanline_render; shadow stores predict every pix word

module tb_tile_background_scanline_render;
  import tbsr_pkg::*;

  // clock, reset and block ports, all known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_word_t req_word = '0;
  logic pix_valid;
  logic pix_stall = 1'b0;
  pix_word_t pix_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  // shadow copy of the three stores and the two config bits
  logic [7:0] pattern_shadow [0:8191];
  logic [7:0] name_shadow [0:4095];
  logic [7:0] palette_shadow [0:15];
  logic pattern_hi_sel = 1'b0;
  logic show_left_sel = 1'b0;

  req_word_t word_queue [$];   // req words not yet offered
  pix_word_t groups_due [$];   // predicted pix words, oldest first
  int failures = 0;
  int req_idle_pct = 0;        // chance of a gap after each req word
  int pix_idle_pct = 0;        // chance of a stall starting on a free cycle
  int req_gap = 0;
  int stall_left = 0;

  tile_background_scanline_render dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_word  (pix_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // idle length: mostly none, short ones often, a long one now and then
  function automatic int pick_idle(int pct);
    int r;
    if ($urandom_range(0, 99) >= pct) return 0;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // name bytes in use; their pattern rows are all filled and they mix every palette group
  function automatic logic [7:0] name_byte(int unsigned n);
    case (n)
      0: return 8'h00;
      1: return 8'h1b;
      2: return 8'he4;
      default: return 8'hff;
    endcase
  endfunction

  function automatic logic [7:0] pick_name();
    return name_byte($urandom_range(0, 3));
  endfunction

  // scroll inside the filled area: tables 0 and 1, coarse y 5, 30 or 31
  function automatic int unsigned rand_scroll();
    logic [4:0] cy;
    case ($urandom_range(0, 2))
      0: cy = 5'd5;
      1: cy = 5'd30;
      default: cy = 5'd31;
    endcase
    return {17'd0, 3'($urandom), 1'b0, 1'($urandom), cy, 5'($urandom)};
  endfunction

  // store write; the render-only fields carry noise
  function automatic req_word_t make_write(kind_t k, int unsigned addr, int unsigned value);
    req_word_t w;
    w.kind = k;
    w.address = addr[12:0];
    w.data = value[7:0];
    w.scroll_address = 15'($urandom);
    w.fine_x = 3'($urandom);
    return w;
  endfunction

  // render request; address and data are don't-care here and carry noise
  function automatic req_word_t make_render(int unsigned scroll, int unsigned fx);
    req_word_t w;
    w.kind = KIND_RENDER;
    w.address = 13'($urandom);
    w.data = 8'($urandom);
    w.scroll_address = scroll[14:0];
    w.fine_x = fx[2:0];
    return w;
  endfunction

  // apply an accepted req word to the shadow stores, or predict its 32 pix words
  task automatic absorb_word(req_word_t w);
    logic [1:0] tbl;
    logic [4:0] cx;
    logic [4:0] cy;
    logic [2:0] fy;
    logic [2:0] sh;
    logic [1:0] grp;
    logic [3:0] pidx;
    logic [7:0] nm;
    logic [7:0] at;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] grp_bits;
    logic [7:0] clip_px;
    logic [7:0] line_buf [0:263];
    logic [7:0] px [0:255];
    pix_word_t g;
    case (w.kind)
      KIND_PATTERN: pattern_shadow[w.address] = w.data;
      KIND_NAME: name_shadow[w.address[11:0]] = w.data;  // upper address bits wrap
      KIND_PALETTE: palette_shadow[w.address[3:0]] = w.data;
      default: begin
        tbl = w.scroll_address[11:10];
        cx = w.scroll_address[4:0];
        cy = w.scroll_address[9:5];
        fy = w.scroll_address[14:12];
        grp = 2'd0;
        // 33 tiles so that fine x can pull in the first pixels of the extra one
        for (int t = 0; t < TILES_PER_ROW + 1; t++) begin
          // coarse y of 30 or 31 lands the name read inside the attribute area
          nm = name_shadow[{tbl, cy, cx}];
          at = name_shadow[{tbl, ATTR_AREA_HI, cy[4:2], cx[4:2]}];
          lo = pattern_shadow[{pattern_hi_sel, nm, 1'b0, fy}];
          hi = pattern_shadow[{pattern_hi_sel, nm, 1'b1, fy}];
          sh = {cy[1], cx[1], 1'b0};
          grp_bits = at >> sh;
          grp = grp_bits[1:0];
          for (int p = 0; p < 8; p++) begin
            pidx = {grp, hi[7 - p], lo[7 - p]};
            line_buf[t * 8 + p] = palette_shadow[pidx];
          end
          cx = cx + 5'd1;
          if (cx == 5'd0) tbl[0] = ~tbl[0];  // column wrap flips horizontal table
        end
        for (int p = 0; p < 256; p++) px[p] = line_buf[p + w.fine_x];
        // left clip uses entry 0 of the group of the last fetched tile
        if (!show_left_sel) begin
          clip_px = palette_shadow[{grp, 2'b00}];
          for (int p = 0; p < 8; p++) px[p] = clip_px;
        end
        for (int k = 0; k < 32; k++) begin
          g.pixel_0 = px[k * 8];
          g.pixel_1 = px[k * 8 + 1];
          g.pixel_2 = px[k * 8 + 2];
          g.pixel_3 = px[k * 8 + 3];
          g.pixel_4 = px[k * 8 + 4];
          g.pixel_5 = px[k * 8 + 5];
          g.pixel_6 = px[k * 8 + 6];
          g.pixel_7 = px[k * 8 + 7];
          g.last = (k == 31);
          groups_due.push_back(g);
        end
      end
    endcase
  endtask

  // compare one accepted pix word against the oldest prediction
  task automatic check_group(pix_word_t got);
    pix_word_t want;
    logic [63:0] got_px;
    logic [63:0] want_px;
    if (groups_due.size() == 0) begin
      $error("pix word %h arrived with nothing expected", got);
      failures++;
      return;
    end
    want = groups_due.pop_front();
    got_px = {got.pixel_0, got.pixel_1, got.pixel_2, got.pixel_3,
              got.pixel_4, got.pixel_5, got.pixel_6, got.pixel_7};
    want_px = {want.pixel_0, want.pixel_1, want.pixel_2, want.pixel_3,
               want.pixel_4, want.pixel_5, want.pixel_6, want.pixel_7};
    for (int i = 0; i < 8; i++) begin
      if (got_px[63 - 8 * i -: 8] !== want_px[63 - 8 * i -: 8]) begin
        $error("pixel_%0d expected %0d actual %0d", i,
               want_px[63 - 8 * i -: 8], got_px[63 - 8 * i -: 8]);
        failures++;
      end
    end
    if (got.last !== want.last) begin
      $error("last expected %0d actual %0d", want.last, got.last);
      failures++;
    end
  endtask

  // req driver: a payload holds while stalled, a random gap, often none, follows each word
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap <= 0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) absorb_word(req_word);  // word taken at this edge
      if (req_gap != 0) begin
        req_valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (word_queue.size() != 0) begin
        req_valid <= 1'b1;
        req_word <= word_queue.pop_front();
        req_gap <= pick_idle(req_idle_pct);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // pix monitor: checks taken words and throws in random stalls
  always @(posedge clk) begin
    int n;
    if (rst) begin
      pix_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (pix_valid && !pix_stall) check_group(pix_word);
      if (stall_left != 0) begin
        pix_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        n = pick_idle(pix_idle_pct);
        pix_stall <= (n != 0);
        stall_left <= (n != 0) ? n - 1 : 0;
      end
    end
  end

  // one config write; shadow copy follows at the accepting edge
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BG_PATTERN_HALF) pattern_hi_sel = value;
    else show_left_sel = value;
  endtask

  // quiet point: nothing queued, nothing in flight, then the pipeline latency
  task automatic wait_idle();
    do @(negedge clk); while (word_queue.size() != 0 || req_valid || groups_due.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int r;
    int unsigned kk;
    int unsigned v;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_BG_PATTERN_HALF, 1'b0);
    write_reg(REG_SHOW_LEFT_BACKGROUND, 1'b0);

    // fill every entry a render can touch: the palette, the pattern rows of the
    // name bytes in use, rows 5, 30 and 31 and the attribute area of tables 0 and 1
    req_idle_pct = 10;
    pix_idle_pct = 10;
    for (int i = 0; i < 16; i++) word_queue.push_back(make_write(KIND_PALETTE, i, $urandom));
    for (int h = 0; h < 2; h++)
      for (int n = 0; n < 4; n++)
        for (int i = 0; i < 16; i++)
          word_queue.push_back(make_write(KIND_PATTERN, {h[0], name_byte(n), i[3:0]},
                                          $urandom));
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < 32; i++)
        word_queue.push_back(make_write(KIND_NAME, {t[1:0], 5'd5, i[4:0]}, pick_name()));
      for (int i = 0; i < 64; i++)
        word_queue.push_back(make_write(KIND_NAME, {t[1:0], 4'b1111, i[5:0]}, pick_name()));
    end
    wait_idle();

    // directed: field extremes, address wrap, attribute area rows, column wraps
    req_idle_pct = 30;
    pix_idle_pct = 30;
    word_queue.push_back(make_write(KIND_PATTERN, 0, 8'h00));
    word_queue.push_back(make_write(KIND_PATTERN, 8191, 8'hff));
    word_queue.push_back(make_write(KIND_NAME, 8191, 8'hff));   // wraps to last table byte
    word_queue.push_back(make_write(KIND_NAME, 5119, 8'he4));   // wraps to end of table 0
    word_queue.push_back(make_write(KIND_PALETTE, 8191, 8'hff)); // wraps to entry 15
    word_queue.push_back(make_write(KIND_PALETTE, 0, 8'h00));
    word_queue.push_back(make_render(5 << 5, 0));
    word_queue.push_back(make_render(15'h77ff, 7));
    word_queue.push_back(make_render(30 << 5, 3));                 // coarse y 30
    word_queue.push_back(make_render((1 << 10) | (31 << 5), 5));   // coarse y 31, table 1
    word_queue.push_back(make_render((1 << 10) | (5 << 5) | 31, 1)); // wrap on the first step
    word_queue.push_back(make_render((7 << 12) | (5 << 5), 0));    // fine y 7
    word_queue.push_back(make_render(rand_scroll(), $urandom));
    wait_idle();
    write_reg(REG_SHOW_LEFT_BACKGROUND, 1'b1);
    word_queue.push_back(make_render(15'h77ff, 7));
    word_queue.push_back(make_render((31 << 5) | 31, 0));
    wait_idle();

    // random phases, each under its own config and pacing
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_BG_PATTERN_HALF, 1'b1); write_reg(REG_SHOW_LEFT_BACKGROUND, 1'b1); end
        1: begin write_reg(REG_BG_PATTERN_HALF, 1'b0); write_reg(REG_SHOW_LEFT_BACKGROUND, 1'b1); end
        2: begin write_reg(REG_BG_PATTERN_HALF, 1'b1); write_reg(REG_SHOW_LEFT_BACKGROUND, 1'b0); end
        3: begin write_reg(REG_BG_PATTERN_HALF, 1'b0); write_reg(REG_SHOW_LEFT_BACKGROUND, 1'b0); end
        default: begin
          write_reg(REG_BG_PATTERN_HALF, 1'($urandom));
          write_reg(REG_SHOW_LEFT_BACKGROUND, 1'($urandom));
        end
      endcase
      // phase 3 runs flat out on both sides
      req_idle_pct = (ph == 3) ? 0 : $urandom_range(5, 50);
      pix_idle_pct = (ph == 3) ? 0 : $urandom_range(5, 50);
      for (int i = 0; i < 18; i++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          word_queue.push_back(make_render(rand_scroll(), $urandom));
        end else begin
          kk = $urandom_range(0, 2);
          // name table bytes stay within the set whose pattern rows are filled
          v = (kind_t'(kk) == KIND_NAME) ? 32'(pick_name()) : $urandom;
          word_queue.push_back(make_write(kind_t'(kk), $urandom, v));
        end
      end
      wait_idle();
    end

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
